// ===== hw/rtl/zbtf_pkg.sv =====
// Package for the z-buffered texture fragment unit.
// Holds screen and texture geometry, request and operation codes, beat and job types.
// No dependencies.
`timescale 1ns / 1ps

package zbtf_pkg;

    localparam int SCREEN_W  = 512;
    localparam int SCREEN_H  = 512;
    localparam int TEX_DIM   = 2048;

    localparam int TEX_CW    = $clog2(TEX_DIM);
    localparam int TEX_N     = TEX_DIM * TEX_DIM;
    localparam int TEX_AW    = $clog2(TEX_N);
    localparam int DEPTH_N   = SCREEN_W * SCREEN_H;
    localparam int DEPTH_AW  = $clog2(DEPTH_N);

    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = $clog2(QDEPTH + 1);

    localparam logic [15:0] FAR_Z    = 16'hffff;
    localparam logic [5:0]  WIN_MASK = 6'h3f;
    localparam logic [6:0]  PAL_MASK = 7'h7f;

    localparam logic [1:0] REQ_TEXWR   = 2'd0;
    localparam logic [1:0] REQ_CLEAR   = 2'd1;
    localparam logic [1:0] REQ_TEXFRAG = 2'd2;
    localparam logic [1:0] REQ_SHADE   = 2'd3;

    typedef enum logic [2:0] {
        OP_TEXWR,
        OP_CLEAR,
        OP_TEXFRAG,
        OP_SHADE,
        OP_SKIP
    } t_op;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [8:0]  pix_x;
        logic [8:0]  pix_y;
        logic [15:0] depth_z;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [15:0] shade;
        logic [15:0] tex_base_word;
        logic        wrap_x;
        logic        wrap_y;
        logic [21:0] texel_addr;
        logic [7:0]  texel_data;
    } t_in_beat;

    typedef struct packed {
        logic        fb_write;
        logic [8:0]  out_x;
        logic [8:0]  out_y;
        logic [15:0] out_color;
    } t_out_beat;

    typedef struct packed {
        t_op                 op;
        logic [8:0]          pix_x;
        logic [8:0]          pix_y;
        logic [15:0]         depth_z;
        logic [15:0]         shade;
        logic [TEX_AW-1:0]   tex_addr;
        logic [7:0]          texel_data;
        logic [DEPTH_AW-1:0] depth_addr;
    } t_job;

    typedef struct packed {
        logic           full;
        logic [QCW-1:0] count;
    } t_q_stat;

    function automatic logic [TEX_CW-1:0] f_tex_coord(
        input logic [15:0] coord,
        input logic [7:0]  base8,
        input logic        wrap
    );
        logic [11:0] t;
        logic [11:0] s;
        t = coord[15:4];
        s = {base8, 4'b0000} + {6'b000000, t[5:0] & WIN_MASK};
        if (wrap) begin
            return s[TEX_CW-1:0];
        end
        return t[TEX_CW-1:0];
    endfunction

endpackage

// ===== hw/rtl/zbuffered_texture_fragment_unit_top.sv =====
// Z-buffered texture fragment unit.
// Input channel (i_in / i_in_valid / o_in_ready) takes one request beat: texel write,
// pixel clear, textured fragment or shaded fragment. Every beat gives exactly one
// result beat on the output channel (o_out / o_out_valid / i_out_ready), in order;
// fb_write marks a framebuffer write, all other result fields are 0 when it is clear.
// Path: an accepted beat is registered in the job queue, the execute register and the
// output register in turn, and waits in the queue behind any older jobs.
// Throughput: one beat per cycle while the output is ready and no clear runs. The depth store does read, compare and
// write in two back-end stages with a one-entry bypass of the write issued alongside
// each read; the texture store is read at issue.
// Reset: the depth store is swept to 0xffff, one entry per cycle over all 262144 entries
// (SCREEN_W * SCREEN_H); o_in_ready stays low until the sweep ends. The texture
// store holds no defined data until written.
// Output stall: the back end holds; the 4-entry job queue keeps accepting until full,
// then o_in_ready drops.
// Depends on zbtf_pkg, zbtf_front, zbtf_queue, zbtf_back, zbtf_ram.
`timescale 1ns / 1ps

module zbuffered_texture_fragment_unit_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zbtf_pkg::t_in_beat  i_in,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output zbtf_pkg::t_out_beat o_out,
    output logic                o_out_valid,
    input  logic                i_out_ready
);
    import zbtf_pkg::*;

    t_q_stat q_stat;
    t_job    push_job;
    t_job    head;
    logic    push;
    logic    pop;
    logic    head_valid;
    logic    clr_busy;

    zbtf_front u_front (
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_q_stat   (q_stat),
        .i_clr_busy (clr_busy),
        .o_push     (push),
        .o_job      (push_job)
    );

    zbtf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_stat       (q_stat)
    );

    zbtf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_clr_busy   (clr_busy),
        .o_out        (o_out),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

    a_clr_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> clr_busy && !o_in_ready)
        else $error("depth clear pass not running after reset");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCW'(QDEPTH))
        else $error("job queue overfilled");

    a_no_issue_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !pop && !o_out_valid)
        else $error("job issued during depth clear");

    a_zero_when_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.fb_write |->
            o_out.out_x == '0 && o_out.out_y == '0 && o_out.out_color == '0)
        else $error("nonzero result fields without framebuffer write");

endmodule

// ===== hw/rtl/zbtf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module zbtf_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/zbtf_front.sv =====
// Front end: input handshake and classification of each beat into a job.
// Computes texture and depth addresses. Depends on zbtf_pkg.
`timescale 1ns / 1ps

module zbtf_front (
    input  zbtf_pkg::t_in_beat i_in,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  zbtf_pkg::t_q_stat  i_q_stat,
    input  logic               i_clr_busy,
    output logic               o_push,
    output zbtf_pkg::t_job     o_job
);
    import zbtf_pkg::*;

    logic              on_screen;
    logic [TEX_CW-1:0] iu;
    logic [TEX_CW-1:0] iv;

    assign o_in_ready = !i_q_stat.full && !i_clr_busy;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        on_screen = (32'(i_in.pix_x) < SCREEN_W) && (32'(i_in.pix_y) < SCREEN_H);
        iu = f_tex_coord(i_in.tex_u, i_in.tex_base_word[7:0], i_in.wrap_x);
        iv = f_tex_coord(i_in.tex_v, i_in.tex_base_word[15:8], i_in.wrap_y);

        o_job.pix_x      = i_in.pix_x;
        o_job.pix_y      = i_in.pix_y;
        o_job.depth_z    = i_in.depth_z;
        o_job.shade      = i_in.shade;
        o_job.texel_data = i_in.texel_data;
        o_job.depth_addr = DEPTH_AW'(32'(i_in.pix_y) * SCREEN_W + 32'(i_in.pix_x));
        o_job.tex_addr   = {iv, iu};
        o_job.op         = OP_SKIP;

        case (i_in.req_type)
            REQ_TEXWR: begin
                o_job.op       = OP_TEXWR;
                o_job.tex_addr = i_in.texel_addr[TEX_AW-1:0];
            end
            REQ_CLEAR:   o_job.op = on_screen ? OP_CLEAR : OP_SKIP;
            REQ_TEXFRAG: o_job.op = on_screen ? OP_TEXFRAG : OP_SKIP;
            REQ_SHADE:   o_job.op = on_screen ? OP_SHADE : OP_SKIP;
            default:     o_job.op = OP_SKIP;
        endcase
    end

endmodule

// ===== hw/rtl/zbtf_queue.sv =====
// Short job queue between the front end and the back end.
// Register based, first in first out. Depends on zbtf_pkg.
`timescale 1ns / 1ps

module zbtf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  zbtf_pkg::t_job    i_job,
    input  logic              i_pop,
    output zbtf_pkg::t_job    o_head,
    output logic              o_head_valid,
    output zbtf_pkg::t_q_stat o_stat
);
    import zbtf_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           do_pop;

    assign o_head_valid = (r_cnt != '0);
    assign do_pop       = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == QCW'(QDEPTH));
    assign o_stat.count = r_cnt;

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + QCW'(i_push) - QCW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== hw/rtl/zbtf_back.sv =====
// Back end: texture and depth stores, depth test, depth update and output register.
// Runs the depth clear pass after reset. Depends on zbtf_pkg and zbtf_ram.
`timescale 1ns / 1ps

module zbtf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zbtf_pkg::t_job      i_head,
    input  logic                i_head_valid,
    output logic                o_pop,
    output logic                o_clr_busy,
    output zbtf_pkg::t_out_beat o_out,
    output logic                o_out_valid,
    input  logic                i_out_ready
);
    import zbtf_pkg::*;

    logic                adv;
    logic                issue;

    logic                r_clr_busy;
    logic [DEPTH_AW-1:0] r_clr_addr;

    t_job                r_e;
    logic                r_e_valid;

    logic                r_fwd_v;
    logic [DEPTH_AW-1:0] r_fwd_addr;
    logic [15:0]         r_fwd_data;

    logic [7:0]          tex_rd;
    logic [15:0]         depth_rd;
    logic [15:0]         stored;
    logic                dwe;
    logic [15:0]         dwd;
    logic                e_dwe;
    t_out_beat           res;

    logic                d_we;
    logic [DEPTH_AW-1:0] d_waddr;
    logic [15:0]         d_wdata;

    t_out_beat           r_out;
    logic                r_out_valid;

    assign adv        = !r_out_valid || i_out_ready;
    assign issue      = adv && i_head_valid && !r_clr_busy;
    assign o_pop      = issue;
    assign o_clr_busy = r_clr_busy;

    zbtf_ram #(.WIDTH(8), .DEPTH(TEX_N)) u_tex (
        .i_clk   (i_clk),
        .i_we    (issue && (i_head.op == OP_TEXWR)),
        .i_waddr (i_head.tex_addr),
        .i_wdata (i_head.texel_data),
        .i_re    (issue),
        .i_raddr (i_head.tex_addr),
        .o_rdata (tex_rd)
    );

    zbtf_ram #(.WIDTH(16), .DEPTH(DEPTH_N)) u_depth (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (issue),
        .i_raddr (i_head.depth_addr),
        .o_rdata (depth_rd)
    );

    // write issued in the same cycle as this job's read is not in the read data
    always_comb begin
        stored = (r_fwd_v && (r_fwd_addr == r_e.depth_addr)) ? r_fwd_data : depth_rd;
        dwe    = 1'b0;
        dwd    = FAR_Z;
        res    = '0;
        case (r_e.op)
            OP_CLEAR: begin
                dwe          = 1'b1;
                dwd          = FAR_Z;
                res.fb_write = 1'b1;
            end
            OP_TEXFRAG: begin
                if ((r_e.depth_z <= stored) && (tex_rd != 8'h00)) begin
                    dwe           = 1'b1;
                    dwd           = r_e.depth_z;
                    res.fb_write  = 1'b1;
                    res.out_color = {1'b0, r_e.shade[6:0] & PAL_MASK, tex_rd};
                end
            end
            OP_SHADE: begin
                if (r_e.depth_z <= stored) begin
                    dwe           = 1'b1;
                    dwd           = r_e.depth_z;
                    res.fb_write  = 1'b1;
                    res.out_color = r_e.shade;
                end
            end
            default: begin
                dwe = 1'b0;
            end
        endcase
        if (res.fb_write) begin
            res.out_x = r_e.pix_x;
            res.out_y = r_e.pix_y;
        end
        e_dwe = adv && r_e_valid && dwe;

        d_we    = r_clr_busy || e_dwe;
        d_waddr = r_clr_busy ? r_clr_addr : r_e.depth_addr;
        d_wdata = r_clr_busy ? FAR_Z : dwd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_e_valid   <= 1'b0;
            r_fwd_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == DEPTH_AW'(DEPTH_N - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_e_valid   <= issue;
                r_fwd_v     <= e_dwe;
                r_out_valid <= r_e_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e        <= i_head;
            r_fwd_addr <= r_e.depth_addr;
            r_fwd_data <= dwd;
            r_out      <= res;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule
